/* rtl/echo_median_presence_detector_macros.svh */
// Assertion macros shared by the echo median presence detector RTL.
// Each macro expects clock aclk and active-low synchronous reset aresetn in scope.
`ifndef ECHO_MEDIAN_PRESENCE_DETECTOR_MACROS_SVH
`define ECHO_MEDIAN_PRESENCE_DETECTOR_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define EMPD_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define EMPD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/empd_pkg.sv */
// Shared types and constants for the echo median presence detector.
// No dependencies; imported by empd_median and the top level.
`default_nettype none

package empd_pkg;

    // Window length default for the sample ring
    localparam int WINDOW_LEN_DEF = 5;

    // Field widths
    localparam int DIST_W     = 14;
    localparam int TIME_W     = 32;
    localparam int ECHO_W     = 15;
    localparam int MS_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Echoes above this width count as a timeout
    localparam logic [ECHO_W-1:0] ECHO_TIMEOUT_US = 15'd30000;

    // echo*16/58 equals (echo*8)/29; divide by 29 via reciprocal ceil(2^23/29),
    // exact for every 18-bit dividend below 2^23/19
    localparam int              X_W         = ECHO_W + 3;
    localparam int              RECIP_W     = 19;
    localparam int              PROD_W      = X_W + RECIP_W;
    localparam int              RECIP_SHIFT = 23;
    localparam logic [RECIP_W-1:0] DIST_RECIP = 19'd289263;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_TOL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL_TIME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd4;

    // Top level sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STORE,
        ST_MSTART,
        ST_MWAIT,
        ST_ZONE,
        ST_TRACK,
        ST_REPORT,
        ST_DONE
    } top_state_t;

    // Median search sequencer
    typedef enum logic [1:0] {
        MED_IDLE,
        MED_SCAN,
        MED_NEXT
    } med_state_t;

    // Median search result
    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] value;
    } med_res_t;

endpackage

`default_nettype wire

/* rtl/empd_median.sv */
// Median search over a window of distances with one shared comparator.
// Depends on empd_pkg for widths, the sequencer enum and the result struct.
`default_nettype none

module empd_median #(
    parameter int WINDOW_LEN = empd_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [empd_pkg::DIST_W-1:0] win [WINDOW_LEN],
    output empd_pkg::med_res_t               res
);
    import empd_pkg::*;

    localparam int K_W   = $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int HALF  = WINDOW_LEN / 2;

    med_state_t        state_reg, state_next;
    logic [DIST_W-1:0] sr_reg [WINDOW_LEN];
    logic [DIST_W-1:0] cand_reg;
    logic [K_W-1:0]    k_reg;
    logic [CNT_W-1:0]  lt_reg, le_reg;

    logic              first, last, hit;
    logic              load_en, rot_en;
    logic [DIST_W-1:0] cmp_val;
    logic [CNT_W-1:0]  lt_new, le_new;

    // Shared compare unit: head of the rotating window against the candidate
    assign first   = (k_reg == '0);
    assign last    = (k_reg == K_W'(WINDOW_LEN - 1));
    assign cmp_val = first ? sr_reg[0] : cand_reg;
    assign lt_new  = (first ? '0 : lt_reg) + CNT_W'(sr_reg[0] <  cmp_val);
    assign le_new  = (first ? '0 : le_reg) + CNT_W'(sr_reg[0] <= cmp_val);
    // Candidate is a median when its rank range covers the middle position
    assign hit     = (lt_new <= CNT_W'(HALF)) && (le_new > CNT_W'(HALF));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MED_IDLE: begin
                if (start) state_next = MED_SCAN;
            end
            MED_SCAN: begin
                if (last) state_next = hit ? MED_IDLE : MED_NEXT;
            end
            MED_NEXT: begin
                state_next = MED_SCAN;
            end
            default: state_next = MED_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        load_en   = 1'b0;
        rot_en    = 1'b0;
        res.done  = 1'b0;
        res.value = cmp_val;
        case (state_reg)
            MED_IDLE: load_en = start;
            MED_SCAN: begin
                rot_en   = 1'b1;
                res.done = last && hit;
            end
            MED_NEXT: rot_en = 1'b1;
            default: ;
        endcase
    end

    // State and scan position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MED_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == MED_SCAN) begin
                k_reg <= last ? '0 : k_reg + K_W'(1);
            end
        end
    end

    // Candidate and rank counters
    always_ff @(posedge aclk) begin
        if (state_reg == MED_SCAN) begin
            if (first) cand_reg <= sr_reg[0];
            lt_reg <= lt_new;
            le_reg <= le_new;
        end
    end

    // Rotating copy of the window
    for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_sr
        localparam int NXT = (g + 1) % WINDOW_LEN;
        always_ff @(posedge aclk) begin
            if (load_en) begin
                sr_reg[g] <= win[g];
            end else if (rot_en) begin
                sr_reg[g] <= sr_reg[NXT];
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/echo_median_presence_detector.sv */
// Echo median presence detector: echo width to distance, ring median, dwell tracking.
// Path from input transaction to result register: CHECK, REPORT and DONE when no sample is stored;
// a stored sample adds STORE, ZONE and TRACK, and once the ring is full also MSTART and the
// median search in MWAIT, which scans the window once per candidate in the shared comparator.
// One item at a time; a new item is taken in the cycle after its result is registered.
// Reset (aresetn low, synchronous) restores register defaults, marks the ring empty and clears tracking.
`default_nettype none

`include "echo_median_presence_detector_macros.svh"

module echo_median_presence_detector #(
    parameter int WINDOW_LEN = empd_pkg::WINDOW_LEN_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [empd_pkg::TIME_W-1:0]     s_now_ms,
    input  wire logic [empd_pkg::ECHO_W-1:0]     s_echo_us,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_sample_taken,
    output logic [empd_pkg::DIST_W-1:0]          m_filtered_distance,
    output logic                                 m_in_zone,
    output logic                                 m_presence_active,
    output logic                                 m_presence_confirmed,
    output logic [empd_pkg::TIME_W-1:0]          m_presence_elapsed_ms,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [empd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [empd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import empd_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_LEN);

    // Sequencer
    top_state_t        state_reg, state_next;
    logic              med_start, out_load;

    // Configuration
    logic [DIST_W-1:0] min_range_reg, max_range_reg, tol_reg;
    logic [MS_W-1:0]   dwell_time_reg, interval_reg;

    // Model state
    logic [DIST_W-1:0] ring_reg [WINDOW_LEN];
    logic [SLOT_W-1:0] write_slot_reg;
    logic              ring_full_reg;
    logic              tracking_reg;
    logic [TIME_W-1:0] dwell_start_reg;
    logic [DIST_W-1:0] ref_dist_reg;
    logic [TIME_W-1:0] last_accept_reg;
    logic [DIST_W-1:0] filt_reg;

    // Per-transaction working registers
    logic [TIME_W-1:0] now_reg;
    logic [ECHO_W-1:0] echo_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              taken_reg;
    logic              zone_hit_reg;
    logic [DIST_W-1:0] delta_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic              in_zone_reg;

    // Output register
    logic              m_valid_reg;
    logic              m_taken_reg, m_in_zone_reg, m_active_reg, m_confirmed_reg;
    logic [DIST_W-1:0] m_dist_reg;
    logic [TIME_W-1:0] m_elapsed_reg;

    // Datapath terms
    logic              interval_ok, echo_ok, slot_last, filt_in_zone;
    logic [X_W-1:0]    echo_x8;
    logic [PROD_W-1:0] prod_comb;
    logic [DIST_W-1:0] dist_new;
    med_res_t          med_res;

    assign interval_ok  = (now_reg - last_accept_reg) >= TIME_W'(interval_reg);
    assign echo_ok      = (echo_reg != '0) && (echo_reg <= ECHO_TIMEOUT_US);
    assign echo_x8      = {echo_reg, 3'b000};
    assign prod_comb    = echo_x8 * DIST_RECIP;
    assign dist_new     = prod_reg[RECIP_SHIFT +: DIST_W];
    assign slot_last    = (write_slot_reg == SLOT_W'(WINDOW_LEN - 1));
    assign filt_in_zone = (filt_reg >= min_range_reg) && (filt_reg <= max_range_reg);

    empd_median #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (med_start),
        .win     (ring_reg),
        .res     (med_res)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = (interval_ok && echo_ok) ? ST_STORE : ST_REPORT;
            end
            ST_STORE: begin
                state_next = (ring_full_reg || slot_last) ? ST_MSTART : ST_ZONE;
            end
            ST_MSTART: state_next = ST_MWAIT;
            ST_MWAIT: begin
                if (med_res.done) state_next = ST_ZONE;
            end
            ST_ZONE:   state_next = ST_TRACK;
            ST_TRACK:  state_next = ST_REPORT;
            ST_REPORT: state_next = ST_DONE;
            ST_DONE: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready   = 1'b0;
        med_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready   = 1'b1;
            ST_MSTART: med_start = 1'b1;
            ST_DONE:   out_load  = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign cfg_ready = 1'b1;

    // Control and model state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            min_range_reg   <= 14'd320;
            max_range_reg   <= 14'd1600;
            tol_reg         <= 14'd80;
            dwell_time_reg  <= 16'd2000;
            interval_reg    <= 16'd100;
            write_slot_reg  <= '0;
            ring_full_reg   <= 1'b0;
            tracking_reg    <= 1'b0;
            dwell_start_reg <= '0;
            ref_dist_reg    <= '0;
            last_accept_reg <= '0;
            filt_reg        <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Take configuration writes; unknown indexes drop
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_RANGE:       min_range_reg  <= cfg_data[DIST_W-1:0];
                    REG_MAX_RANGE:       max_range_reg  <= cfg_data[DIST_W-1:0];
                    REG_STABLE_TOL:      tol_reg        <= cfg_data[DIST_W-1:0];
                    REG_DWELL_TIME:      dwell_time_reg <= cfg_data[MS_W-1:0];
                    REG_SAMPLE_INTERVAL: interval_reg   <= cfg_data[MS_W-1:0];
                    default: ;
                endcase
            end

            // Record the accept time once the interval has elapsed
            if (state_reg == ST_CHECK && interval_ok) begin
                last_accept_reg <= now_reg;
            end

            // Advance the write slot and fill state
            if (state_reg == ST_STORE) begin
                write_slot_reg <= slot_last ? '0 : write_slot_reg + SLOT_W'(1);
                if (slot_last) ring_full_reg <= 1'b1;
                if (!(ring_full_reg || slot_last)) filt_reg <= dist_new;
            end

            if (state_reg == ST_MWAIT && med_res.done) begin
                filt_reg <= med_res.value;
            end

            // Update presence tracking
            if (state_reg == ST_TRACK) begin
                if (zone_hit_reg) begin
                    if (!tracking_reg || (delta_reg > tol_reg)) begin
                        tracking_reg    <= 1'b1;
                        dwell_start_reg <= now_reg;
                        ref_dist_reg    <= filt_reg;
                    end
                end else begin
                    tracking_reg    <= 1'b0;
                    dwell_start_reg <= '0;
                    ref_dist_reg    <= '0;
                end
            end

            // Hold the result until the transaction completes
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers and result payload
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    now_reg   <= s_now_ms;
                    echo_reg  <= s_echo_us;
                    taken_reg <= 1'b0;
                end
            end
            ST_CHECK: prod_reg <= prod_comb;
            ST_STORE: begin
                ring_reg[write_slot_reg] <= dist_new;
                taken_reg                <= 1'b1;
            end
            ST_ZONE: begin
                zone_hit_reg <= filt_in_zone;
                delta_reg    <= (filt_reg >= ref_dist_reg) ? filt_reg - ref_dist_reg
                                                           : ref_dist_reg - filt_reg;
            end
            ST_REPORT: begin
                elapsed_reg <= tracking_reg ? now_reg - dwell_start_reg : '0;
                in_zone_reg <= ring_full_reg && filt_in_zone;
            end
            ST_DONE: begin
                if (out_load) begin
                    m_taken_reg     <= taken_reg;
                    m_dist_reg      <= filt_reg;
                    m_in_zone_reg   <= in_zone_reg;
                    m_active_reg    <= tracking_reg;
                    m_confirmed_reg <= tracking_reg &&
                                       (elapsed_reg >= TIME_W'(dwell_time_reg));
                    m_elapsed_reg   <= elapsed_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid               = m_valid_reg;
    assign m_sample_taken        = m_taken_reg;
    assign m_filtered_distance   = m_dist_reg;
    assign m_in_zone             = m_in_zone_reg;
    assign m_presence_active     = m_active_reg;
    assign m_presence_confirmed  = m_confirmed_reg;
    assign m_presence_elapsed_ms = m_elapsed_reg;

    // Checks
    `EMPD_ASSERT_ALWAYS(a_slot_range, write_slot_reg <= SLOT_W'(WINDOW_LEN - 1), "write slot past ring end")
    `EMPD_ASSERT_IMPL(a_med_done_wait, med_res.done, state_reg == ST_MWAIT, "median result outside wait")
    `EMPD_ASSERT_IMPL(a_zone_needs_full, m_valid && m_in_zone, ring_full_reg, "in zone before ring full")
    `EMPD_ASSERT_IMPL(a_idle_elapsed, m_valid && !m_presence_active, (m_presence_elapsed_ms == '0) && !m_presence_confirmed, "dwell reported while not tracking")

endmodule

`default_nettype wire
